// ----- rtl/skyatl_pkg.sv -----
// Shared types and constants of the skyline atlas block allocator.
package skyatl_pkg;

   localparam int MAX_COLUMNS_DEF = 256;
   localparam int MAX_ROWS_DEF    = 1024;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_ATLAS_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATLAS_HEIGHT = 1'b1;

   localparam logic [8:0]  ATLAS_WIDTH_RST  = 9'd256;
   localparam logic [10:0] ATLAS_HEIGHT_RST = 11'd1024;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [8:0]  req_width;
      logic [10:0] req_height;
   } req_item_type;

   typedef struct packed {
      logic        granted;
      logic [7:0]  pos_x;
      logic [9:0]  pos_y;
   } rsp_item_type;

   typedef struct packed {
      logic [8:0]  atlas_width;
      logic [10:0] atlas_height;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic ack;
   } core_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

endpackage

// ----- rtl/skyatl_core.sv -----
// Column fill store, prefix store and the sequencer that scans and updates them.
module skyatl_core #(
   parameter int MAX_COLUMNS = skyatl_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = skyatl_pkg::MAX_ROWS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  skyatl_pkg::cfg_type      cfg,
   input  skyatl_pkg::core_ctl_type ctl,
   input  skyatl_pkg::req_item_type item,
   output skyatl_pkg::core_stat_type stat,
   output skyatl_pkg::rsp_item_type result
);
   import skyatl_pkg::*;

   localparam int CW  = $clog2(MAX_COLUMNS);
   localparam int CNW = $clog2(MAX_COLUMNS + 1);
   localparam int RW  = $clog2(MAX_ROWS + 1);
   localparam int SW  = ((RW > 11) ? RW : 11) + 1;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CLEAR = 9'b000000010,
      ST_PASS1 = 9'b000000100,
      ST_TURN  = 9'b000001000,
      ST_PASS2 = 9'b000010000,
      ST_TAIL  = 9'b000100000,
      ST_EVAL  = 9'b001000000,
      ST_WRITE = 9'b010000000,
      ST_DONE  = 9'b100000000
   } core_state_type;

   function automatic logic [RW-1:0] max_f(input logic [RW-1:0] a, input logic [RW-1:0] b);
      max_f = (a > b) ? a : b;
   endfunction

   core_state_type state_ff, state_in;
   logic [CW-1:0]  k_ff, k_in;
   logic [CW-1:0]  off_ff, off_in;
   logic [CW-1:0]  w_ff, w_in;
   logic [10:0]    h_ff, h_in;
   logic [RW-1:0]  rows_ff, rows_in;
   logic [CW-1:0]  last_ff, last_in;
   logic [CW-1:0]  nwin_ff, nwin_in;
   logic           quiet_ff, quiet_in;
   logic           pipe_vld_ff, pipe_vld_in;
   logic           pipe_mode_ff, pipe_mode_in;
   logic [CW-1:0]  pipe_k_ff, pipe_k_in;
   logic [CW-1:0]  pipe_off_ff, pipe_off_in;
   logic [RW-1:0]  prun_ff, prun_in;
   logic [RW-1:0]  srun_ff, srun_in;
   logic [RW-1:0]  best_ff, best_in;
   logic [CW-1:0]  bx_ff, bx_in;
   logic           found_ff, found_in;
   rsp_item_type   res_ff, res_in;

   logic [RW-1:0]  fill_mem_ff [MAX_COLUMNS];
   logic [RW-1:0]  pre_mem_ff [MAX_COLUMNS];
   logic [RW-1:0]  fill_rd_ff, pre_rd_ff;
   logic           fill_we, pre_we;
   logic [CW-1:0]  fill_wa, fill_ra, pre_wa, pre_ra;
   logic [RW-1:0]  fill_wd, pre_wd;

   logic [CNW-1:0] cols_c;
   logic [RW-1:0]  rows_c;
   logic           bad_c;
   logic [SW-1:0]  sum_c;
   logic [RW-1:0]  pmax_c, smax_c, wmax_c;
   logic           blockend_c;
   logic [CW:0]    pre_sum_c;

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem_ff[fill_wa] <= fill_wd;
      end
      fill_rd_ff <= fill_mem_ff[fill_ra];
   end

   always_ff @(posedge clock) begin
      if (pre_we) begin
         pre_mem_ff[pre_wa] <= pre_wd;
      end
      pre_rd_ff <= pre_mem_ff[pre_ra];
   end

   always_comb begin
      cols_c = (32'(cfg.atlas_width) > 32'(MAX_COLUMNS)) ? CNW'(MAX_COLUMNS)
                                                         : CNW'(cfg.atlas_width);
      rows_c = (32'(cfg.atlas_height) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS)
                                                       : RW'(cfg.atlas_height);
      bad_c  = (item.req_width == 9'd0) || (item.req_height == 11'd0) ||
               (32'(item.req_width) >= 32'(cols_c));
      sum_c  = SW'(best_ff) + SW'(h_ff);
      pre_sum_c = {1'b0, k_ff} + {1'b0, w_ff} - (CW+1)'(1);
      pmax_c = (pipe_off_ff == '0) ? fill_rd_ff : max_f(prun_ff, fill_rd_ff);
      blockend_c = (pipe_off_ff == (w_ff - CW'(1))) || (pipe_k_ff == last_ff);
      smax_c = blockend_c ? fill_rd_ff : max_f(srun_ff, fill_rd_ff);
      wmax_c = max_f(smax_c, pre_rd_ff);
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      off_in       = off_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      rows_in      = rows_ff;
      last_in      = last_ff;
      nwin_in      = nwin_ff;
      quiet_in     = quiet_ff;
      pipe_vld_in  = 1'b0;
      pipe_mode_in = pipe_mode_ff;
      pipe_k_in    = k_ff;
      pipe_off_in  = off_ff;
      prun_in      = prun_ff;
      srun_in      = srun_ff;
      best_in      = best_ff;
      bx_in        = bx_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      fill_we      = 1'b0;
      fill_wa      = k_ff;
      fill_wd      = '0;
      fill_ra      = k_ff;
      pre_we       = 1'b0;
      pre_wa       = pipe_k_ff;
      pre_wd       = pmax_c;
      pre_ra       = pre_sum_c[CW-1:0];

      // Result stage of the registered read pipeline.
      if (pipe_vld_ff && !pipe_mode_ff) begin
         pre_we  = 1'b1;
         prun_in = pmax_c;
      end
      if (pipe_vld_ff && pipe_mode_ff) begin
         srun_in = smax_c;
         if (pipe_k_ff <= nwin_ff) begin
            if (!found_ff || (wmax_c <= best_ff)) begin
               best_in  = wmax_c;
               bx_in    = pipe_k_ff;
               found_in = 1'b1;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               k_in   = '0;
               off_in = '0;
               if (item.cmd == CMD_CLEAR) begin
                  quiet_in = 1'b0;
                  res_in   = '{granted: 1'b1, pos_x: 8'd0, pos_y: 10'd0};
                  state_in = ST_CLEAR;
               end else if (bad_c) begin
                  res_in   = '{granted: 1'b0, pos_x: 8'd0, pos_y: 10'd0};
                  state_in = ST_DONE;
               end else begin
                  w_in     = CW'(item.req_width);
                  h_in     = item.req_height;
                  rows_in  = rows_c;
                  last_in  = CW'(32'(cols_c) - 32'd2);
                  nwin_in  = CW'(32'(cols_c) - 32'(item.req_width) - 32'd1);
                  found_in = 1'b0;
                  state_in = ST_PASS1;
               end
            end
         end
         ST_CLEAR: begin
            fill_we = 1'b1;
            k_in    = k_ff + CW'(1);
            if (k_ff == CW'(MAX_COLUMNS - 1)) begin
               state_in = quiet_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_PASS1: begin
            pipe_vld_in  = 1'b1;
            pipe_mode_in = 1'b0;
            off_in = (off_ff == (w_ff - CW'(1))) ? '0 : off_ff + CW'(1);
            k_in   = k_ff + CW'(1);
            if (k_ff == last_ff) begin
               state_in = ST_TURN;
            end
         end
         ST_TURN: begin
            // The pipe now holds the last column, so its offset seeds the backward pass.
            off_in   = pipe_off_ff;
            k_in     = last_ff;
            state_in = ST_PASS2;
         end
         ST_PASS2: begin
            pipe_vld_in  = 1'b1;
            pipe_mode_in = 1'b1;
            off_in = (off_ff == '0) ? w_ff - CW'(1) : off_ff - CW'(1);
            k_in   = k_ff - CW'(1);
            if (k_ff == '0) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            k_in = '0;
            if (sum_c <= SW'(rows_ff)) begin
               res_in   = '{granted: 1'b1, pos_x: 8'(bx_ff), pos_y: 10'(best_ff)};
               state_in = ST_WRITE;
            end else begin
               res_in   = '{granted: 1'b0, pos_x: 8'd0, pos_y: 10'd0};
               state_in = ST_DONE;
            end
         end
         ST_WRITE: begin
            fill_we = 1'b1;
            fill_wa = bx_ff + k_ff;
            fill_wd = RW'(sum_c);
            k_in    = k_ff + CW'(1);
            if (k_ff == (w_ff - CW'(1))) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ctl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         k_ff        <= '0;
         quiet_ff    <= 1'b1;
         pipe_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         quiet_ff    <= quiet_in;
         pipe_vld_ff <= pipe_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff       <= off_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      rows_ff      <= rows_in;
      last_ff      <= last_in;
      nwin_ff      <= nwin_in;
      pipe_mode_ff <= pipe_mode_in;
      pipe_k_ff    <= pipe_k_in;
      pipe_off_ff  <= pipe_off_in;
      prun_ff      <= prun_in;
      srun_ff      <= srun_in;
      best_ff      <= best_in;
      bx_ff        <= bx_in;
      found_ff     <= found_in;
      res_ff       <= res_in;
   end

   assign stat.idle = (state_ff == ST_IDLE);
   assign stat.done = (state_ff == ST_DONE);
   assign result    = res_ff;

endmodule

// ----- rtl/skyline_atlas_block_allocator_unit.sv -----
// Top level of the skyline texture atlas block allocator.
//
// This block places rectangles into a texture atlas with the skyline method. It keeps one
// fill height per column in a small memory. An allocate item carries a width and a height;
// the block looks at every start column from zero up to atlas_width - req_width - 1 (the
// rightmost possible start column is never tried), takes the highest fill over each window
// and picks the first window whose highest fill is lowest. If that fill plus the height fits
// within atlas_height, the window's columns are raised and the left column and top row come
// back with granted set; otherwise granted is low and the position is zero. A clear item
// empties all columns and returns granted with a zero position. One item is worked at a time
// and req_stall stays high until it is finished. The fill memory has a single read port,
// and the window maxima come from two passes over the columns, whose count is atlas_width
// limited to MAX_COLUMNS (a forward pass that records block prefix maxima, a backward pass
// that forms suffix maxima and compares each window), one column per cycle, followed by
// one write per column of the placed rectangle. An item with a zero size or a width not
// below that column count is refused before the scan. After reset the block sweeps the
// fill memory to zero and holds req_stall high meanwhile; configuration writes are taken
// at any time but are meant to be done while no item is in flight. The finished result
// sits in an output register, so the next item can be taken while the previous result is
// still stalled.
module skyline_atlas_block_allocator_unit #(
   parameter int MAX_COLUMNS = skyatl_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = skyatl_pkg::MAX_ROWS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  skyatl_pkg::req_item_type               req_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output skyatl_pkg::rsp_item_type               rsp_item,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [skyatl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [skyatl_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import skyatl_pkg::*;

   logic [8:0]    atlas_width_ff, atlas_width_in;
   logic [10:0]   atlas_height_ff, atlas_height_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;

   cfg_type       cfg;
   core_ctl_type  ctl;
   core_stat_type stat;
   rsp_item_type  core_result;

   // The register file is always ready; writes simply land in the next cycle.
   assign csr_ready = 1'b1;

   always_comb begin
      atlas_width_in  = atlas_width_ff;
      atlas_height_in = atlas_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ATLAS_WIDTH:  atlas_width_in  = csr_wdata[8:0];
            CSR_ATLAS_HEIGHT: atlas_height_in = csr_wdata[10:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.atlas_width  = atlas_width_ff;
   assign cfg.atlas_height = atlas_height_ff;

   // A new item is taken only while the sequencer is idle.
   assign req_stall = !stat.idle;
   assign ctl.start = req_valid && !req_stall;

   // The finished result moves into the output register when that register is free or
   // is being emptied in the same cycle.
   assign ctl.ack = stat.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (ctl.ack) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = core_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_width_ff  <= ATLAS_WIDTH_RST;
         atlas_height_ff <= ATLAS_HEIGHT_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         atlas_width_ff  <= atlas_width_in;
         atlas_height_ff <= atlas_height_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   skyatl_core #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .ctl    (ctl),
      .item   (req_item),
      .stat   (stat),
      .result (core_result)
   );

endmodule

// ----- rtl/skyatl_checker.sv -----
// Port-level checks of the allocator and the bind that attaches them.
module skyatl_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input skyatl_pkg::req_item_type           req_item,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input skyatl_pkg::rsp_item_type           rsp_item,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [skyatl_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [skyatl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import skyatl_pkg::*;

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // A refusal carries a zero position.
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.granted |-> (rsp_item.pos_x == 8'd0) && (rsp_item.pos_y == 10'd0))
      else $error("refused result with nonzero position");

   // Work on an item keeps the sequencer busy, so the input stalls right after acceptance.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after an accepted item");

   // A fresh result only appears from a busy block.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

endmodule

bind skyline_atlas_block_allocator_unit skyatl_checker u_skyatl_checker (.*);

// ----- verif/skyline_atlas_block_allocator_checker.sv -----
// Checker that predicts and compares the placements of the skyline atlas allocator.
`timescale 1ns / 1ps

module skyline_atlas_block_allocator_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  skyatl_pkg::req_item_type           req_item,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  skyatl_pkg::rsp_item_type           rsp_item,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [skyatl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [skyatl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                        pending,
   output int unsigned                        fail_count
);
   import skyatl_pkg::*;

   localparam int COLS_MAX = MAX_COLUMNS_DEF;
   localparam int ROWS_MAX = MAX_ROWS_DEF;

   logic [8:0]   atlas_w;
   logic [10:0]  atlas_h;
   logic [10:0]  column_height [COLS_MAX];
   rsp_item_type expected_placements [$];
   int unsigned  mismatches = 0;

   assign fail_count = mismatches;

   // Works out the placement of one item and updates the column heights.
   function automatic rsp_item_type place_rect(input req_item_type it);
      int unsigned  cols;
      int unsigned  rows;
      int unsigned  w;
      int unsigned  lowest;
      int unsigned  peak;
      int unsigned  best_x;
      int unsigned  best_y;
      bit           found;
      bit           fits;
      rsp_item_type r;
      r      = '0;
      cols   = (atlas_w > COLS_MAX) ? COLS_MAX : atlas_w;
      rows   = (atlas_h > ROWS_MAX) ? ROWS_MAX : atlas_h;
      w      = it.req_width;
      found  = 1'b0;
      best_x = 0;
      best_y = rows;
      lowest = rows;
      if (it.cmd == CMD_CLEAR) begin
         foreach (column_height[i]) column_height[i] = '0;
         r.granted = 1'b1;
         return r;
      end
      if (w == 0 || it.req_height == 0 || w >= cols)
         return r;
      // The rightmost start column is left out of the scan on purpose.
      for (int x = 0; x < cols - w; x++) begin
         peak = 0;
         fits = 1'b1;
         for (int j = 0; j < w && fits; j++) begin
            if (column_height[x + j] >= lowest)
               fits = 1'b0;
            else if (column_height[x + j] > peak)
               peak = column_height[x + j];
         end
         if (fits) begin
            best_x = x;
            best_y = peak;
            lowest = peak;
            found  = 1'b1;
         end
      end
      if (!found || best_y + it.req_height > rows)
         return r;
      for (int j = 0; j < w; j++)
         column_height[best_x + j] = 11'(best_y + it.req_height);
      r.granted = 1'b1;
      r.pos_x   = 8'(best_x);
      r.pos_y   = 10'(best_y);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         atlas_w = ATLAS_WIDTH_RST;
         atlas_h = ATLAS_HEIGHT_RST;
         foreach (column_height[i]) column_height[i] = '0;
         expected_placements.delete();
      end else begin
         // Results are checked before the new item is predicted, since a result
         // accepted at the same edge belongs to an earlier item.
         if (rsp_valid && !rsp_stall) begin
            if (expected_placements.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result granted %0d x %0d y %0d", $realtime,
                           rsp_item.granted, rsp_item.pos_x, rsp_item.pos_y);
            end else begin
               want = expected_placements.pop_front();
               if (rsp_item.granted !== want.granted || rsp_item.pos_x !== want.pos_x ||
                   rsp_item.pos_y !== want.pos_y) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: placement mismatch, expected granted %0d x %0d y %0d,",
                               " got granted %0d x %0d y %0d"},
                              $realtime, want.granted, want.pos_x, want.pos_y,
                              rsp_item.granted, rsp_item.pos_x, rsp_item.pos_y);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ATLAS_WIDTH)
               atlas_w = csr_wdata[8:0];
            else
               atlas_h = csr_wdata;
         end
         if (req_valid && !req_stall)
            expected_placements.push_back(place_rect(req_item));
      end
      pending <= expected_placements.size();
   end

endmodule

// ----- verif/skyline_atlas_block_allocator_unit_tb.sv -----
// Testbench top that drives the skyline atlas allocator and reports the verdict.
`timescale 1ns / 1ps

module skyline_atlas_block_allocator_unit_tb;
   import skyatl_pkg::*;

   // A stalled result can wait this long while the sender keeps offering items,
   // which fills the output register and the working slot and stalls the input.
   localparam int unsigned HOLD_CYCLES = 3000;
   // Cycles without any accepted item, result or register write before giving up.
   // This leaves a wide margin over the slowest item, the long hold, the reset sweep
   // and the longest random gaps.
   localparam int unsigned WATCHDOG_LIMIT = 20000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_item_type           req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_item_type           rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int unsigned pending;
   int unsigned fail_count;

   // Idling knobs. The stall percentage is read by the result side at each edge,
   // so it is only ever changed with a nonblocking assignment.
   int unsigned stall_pct     = 0;
   int unsigned send_idle_pct = 0;
   logic        hold_toggle   = 1'b0;
   logic        hold_seen     = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned idle_cycles   = 0;

   // Effective atlas size last written, used only to shape random items.
   int unsigned cur_cols = 256;
   int unsigned cur_rows = 1024;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   skyline_atlas_block_allocator_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   skyline_atlas_block_allocator_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .fail_count (fail_count)
   );

   // Result side. A flip of hold_toggle starts a long hold-off that is counted
   // here; otherwise the stall is drawn at random each cycle.
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= (hold_toggle != hold_seen) || (hold_left > 1) ||
                   ($urandom_range(99) < stall_pct);
   end

   // Watchdog: any accepted item, result or register write restarts the count.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one item, after an optional random gap, and holds it until taken.
   // Valid stays high afterwards so back-to-back items never drop it.
   task automatic send_item(input req_item_type it);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic push_rect(input logic cmd, input logic [8:0] w, input logic [10:0] h);
      req_item_type it;
      it.cmd        = cmd;
      it.req_width  = w;
      it.req_height = h;
      send_item(it);
   endtask

   // Stops offering items and waits until every outstanding result has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Writes both atlas registers once the block has gone idle. Valid stays high
   // across the two writes and drops only after the second one is taken.
   task automatic set_atlas(input logic [CSR_DATA_W-1:0] width_val,
                            input logic [CSR_DATA_W-1:0] height_val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_ATLAS_WIDTH;
      csr_wdata <= width_val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_ATLAS_HEIGHT;
      csr_wdata <= height_val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_cols = (width_val[8:0] > 9'd256) ? 256 : width_val[8:0];
      cur_rows = (height_val > 11'd1024) ? 1024 : height_val;
   endtask

   task automatic set_idling(input int unsigned mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            stall_pct    <= 0;
         end
         1: begin
            send_idle_pct = 88;
            stall_pct    <= 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct    <= 88;
         end
         default: begin
            send_idle_pct = 21;
            stall_pct    <= 21;
         end
      endcase
   endtask

   // Mostly well-formed allocations that fill the atlas until requests get
   // refused, with occasional clears to start over, plus some noise across the
   // full range of every field.
   function automatic req_item_type random_item();
      req_item_type it;
      int unsigned  roll;
      int unsigned  wmax;
      int unsigned  hmax;
      roll          = $urandom_range(99);
      wmax          = (cur_cols / 3 > 1) ? cur_cols / 3 : 1;
      hmax          = (cur_rows / 6 > 1) ? cur_rows / 6 : 1;
      it.cmd        = CMD_ALLOC;
      it.req_width  = 9'($urandom_range(1, wmax));
      it.req_height = 11'($urandom_range(1, hmax));
      if (roll < 4) begin
         it.cmd        = CMD_CLEAR;
         it.req_width  = 9'($urandom);
         it.req_height = 11'($urandom);
      end else if (roll < 14) begin
         it.req_width  = 9'($urandom);
         it.req_height = 11'($urandom);
      end else if (roll < 17) begin
         if ($urandom_range(1))
            it.req_width = '0;
         else
            it.req_height = '0;
      end else if (roll < 21) begin
         // Widths at the edge of the atlas: only the leftmost window, or none.
         it.req_width = 9'(cur_cols - $urandom_range(1, 0));
      end else if (roll < 24) begin
         it.req_height = 11'(cur_rows - $urandom_range(2, 0));
      end
      return it;
   endfunction

   initial begin
      int unsigned n_items;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);

      // Directed part at the reset size of 256 columns by 1024 rows.
      push_rect(CMD_CLEAR, 9'd0, 11'd0);
      push_rect(CMD_ALLOC, 9'd1, 11'd1);
      push_rect(CMD_ALLOC, 9'd255, 11'd1);     // only the leftmost window exists
      push_rect(CMD_ALLOC, 9'd256, 11'd1);     // as wide as the atlas, refused
      push_rect(CMD_ALLOC, 9'd511, 11'd2047);
      push_rect(CMD_ALLOC, 9'd0, 11'd5);       // zero width
      push_rect(CMD_ALLOC, 9'd3, 11'd0);       // zero height
      push_rect(CMD_ALLOC, 9'd1, 11'd2047);    // taller than the atlas
      push_rect(CMD_ALLOC, 9'd4, 11'd1024);
      push_rect(CMD_ALLOC, 9'd1, 11'd1022);    // fills a column to the top exactly
      push_rect(CMD_ALLOC, 9'd1, 11'd1);

      // Smallest usable atlas: two columns, one row.
      set_atlas(11'd2, 11'd1);
      push_rect(CMD_CLEAR, 9'h1FF, 11'h7FF);
      push_rect(CMD_ALLOC, 9'd1, 11'd1);
      push_rect(CMD_ALLOC, 9'd1, 11'd1);       // full, refused
      push_rect(CMD_ALLOC, 9'd2, 11'd1);

      // Degenerate sizes refuse everything.
      set_atlas(11'd1, 11'd1024);
      push_rect(CMD_ALLOC, 9'd1, 11'd1);
      set_atlas(11'd0, 11'd1024);
      push_rect(CMD_ALLOC, 9'd1, 11'd1);
      set_atlas(11'd256, 11'd0);
      push_rect(CMD_ALLOC, 9'd1, 11'd1);

      // Register values beyond the limits act as the limits.
      set_atlas(11'h7FF, 11'h7FF);
      push_rect(CMD_CLEAR, 9'd0, 11'd0);
      push_rect(CMD_ALLOC, 9'd255, 11'd1024);
      push_rect(CMD_ALLOC, 9'd1, 11'd1);       // the untried last column stays empty

      // Lowering the height leaves taller columns in place; they never qualify.
      set_atlas(11'd256, 11'd20);
      push_rect(CMD_ALLOC, 9'd1, 11'd1);
      push_rect(CMD_CLEAR, 9'd0, 11'd0);
      push_rect(CMD_ALLOC, 9'd10, 11'd5);
      set_atlas(11'd256, 11'd3);
      push_rect(CMD_ALLOC, 9'd1, 11'd1);

      // Random part: ten phases, each with its own atlas size and idling.
      for (int p = 0; p < 10; p++) begin
         case (p)
            0: set_atlas(11'd256, 11'd1024);
            5: set_atlas(11'h7FF, 11'h7FF);
            7: set_atlas(11'd2, 11'($urandom_range(1, 1024)));
            default: set_atlas(11'($urandom_range(3, 40)), 11'($urandom_range(8, 1024)));
         endcase
         set_idling(p % 4);
         n_items = (p == 0) ? 100 : (p == 5) ? 60 : 120;
         for (int k = 0; k < n_items; k++) begin
            if ((p == 4 || p == 8) && k == 10)
               hold_toggle <= ~hold_toggle;
            if (p == 6 && k == 60)
               drain();
            send_item(random_item());
         end
      end

      drain();
      repeat (1000) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
